### rtl/ll1p_pkg.sv
// ll1p_pkg: shared constants, types and grammar tables of the ll1 statement parser
// no dependencies; used by every other file of the block
package ll1p_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int FILL_W      = $clog2(STACK_DEPTH + 1);
  localparam int SYM_W       = 6;
  localparam int TOK_W       = 5;
  localparam int RULE_MAX    = 5;
  localparam int LEN_W       = 3;
  localparam int RULE_W      = 4;
  localparam int FLAG_W      = 4;
  localparam int KIND_W      = 3;
  localparam int MAX_EXPAND  = 64;
  localparam int ITER_W      = $clog2(MAX_EXPAND + 1);

  // lexer tokens
  localparam logic [TOK_W-1:0] TK_END    = 5'd0;
  localparam logic [TOK_W-1:0] TK_ELSE   = 5'd8;
  localparam logic [TOK_W-1:0] TK_IF     = 5'd6;
  localparam logic [TOK_W-1:0] TK_THEN   = 5'd7;
  localparam logic [TOK_W-1:0] TK_DO     = 5'd9;
  localparam logic [TOK_W-1:0] TK_WHILE  = 5'd10;
  localparam logic [TOK_W-1:0] TK_CONST  = 5'd11;
  localparam logic [TOK_W-1:0] TK_IDENT  = 5'd12;
  localparam logic [TOK_W-1:0] TK_PLUS   = 5'd13;
  localparam logic [TOK_W-1:0] TK_MINUS  = 5'd14;
  localparam logic [TOK_W-1:0] TK_MUL    = 5'd15;
  localparam logic [TOK_W-1:0] TK_DIV    = 5'd16;
  localparam logic [TOK_W-1:0] TK_LPAR   = 5'd17;
  localparam logic [TOK_W-1:0] TK_RPAR   = 5'd18;
  localparam logic [TOK_W-1:0] TK_SEMI   = 5'd22;
  localparam logic [TOK_W-1:0] TK_ASSIGN = 5'd24;

  // stack symbols: terminals are the token codes, nonterminals from 32 up
  localparam logic [SYM_W-1:0] SY_ELSE   = 6'd8;
  localparam logic [SYM_W-1:0] SY_IF     = 6'd6;
  localparam logic [SYM_W-1:0] SY_THEN   = 6'd7;
  localparam logic [SYM_W-1:0] SY_DO     = 6'd9;
  localparam logic [SYM_W-1:0] SY_WHILE  = 6'd10;
  localparam logic [SYM_W-1:0] SY_IDENT  = 6'd12;
  localparam logic [SYM_W-1:0] SY_PLUS   = 6'd13;
  localparam logic [SYM_W-1:0] SY_MINUS  = 6'd14;
  localparam logic [SYM_W-1:0] SY_MUL    = 6'd15;
  localparam logic [SYM_W-1:0] SY_DIV    = 6'd16;
  localparam logic [SYM_W-1:0] SY_LPAR   = 6'd17;
  localparam logic [SYM_W-1:0] SY_RPAR   = 6'd18;
  localparam logic [SYM_W-1:0] SY_SEMI   = 6'd22;
  localparam logic [SYM_W-1:0] SY_ASSIGN = 6'd24;
  localparam logic [SYM_W-1:0] NT_S      = 6'd32;
  localparam logic [SYM_W-1:0] NT_A      = 6'd33;
  localparam logic [SYM_W-1:0] NT_B      = 6'd34;
  localparam logic [SYM_W-1:0] NT_E      = 6'd35;
  localparam logic [SYM_W-1:0] NT_T      = 6'd36;
  localparam logic [SYM_W-1:0] NT_G      = 6'd37;
  localparam logic [SYM_W-1:0] NT_F      = 6'd38;
  localparam logic [SYM_W-1:0] NT_H      = 6'd39;
  localparam logic [SYM_W-1:0] NT_I      = 6'd40;

  // rule numbers
  localparam logic [RULE_W-1:0] R_S_B     = 4'd0;
  localparam logic [RULE_W-1:0] R_S_A     = 4'd1;
  localparam logic [RULE_W-1:0] R_B_IF    = 4'd2;
  localparam logic [RULE_W-1:0] R_B_WHILE = 4'd3;
  localparam logic [RULE_W-1:0] R_A       = 4'd4;
  localparam logic [RULE_W-1:0] R_E       = 4'd5;
  localparam logic [RULE_W-1:0] R_T       = 4'd6;
  localparam logic [RULE_W-1:0] R_G_PLUS  = 4'd7;
  localparam logic [RULE_W-1:0] R_G_MINUS = 4'd8;
  localparam logic [RULE_W-1:0] R_F_ID    = 4'd9;
  localparam logic [RULE_W-1:0] R_F_PAR   = 4'd10;
  localparam logic [RULE_W-1:0] R_H_MUL   = 4'd11;
  localparam logic [RULE_W-1:0] R_H_DIV   = 4'd12;
  localparam logic [RULE_W-1:0] R_I_ELSE  = 4'd13;
  localparam logic [RULE_W-1:0] R_EMPTY   = 4'd14;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_EXPAND,
    OP_RESTART
  } stack_op_t;

  typedef logic [RULE_MAX-1:0][SYM_W-1:0] rule_syms_t;

  // one step for the chain of stack cells: pop the top, push len symbols
  typedef struct packed {
    stack_op_t            op;
    logic [LEN_W-1:0]     len;
    rule_syms_t           syms;
  } stack_cmd_t;

  typedef struct packed {
    logic              hit;
    logic [RULE_W-1:0] rule;
  } predict_t;

  function automatic predict_t predict(input logic [SYM_W-1:0] nt,
                                       input logic [TOK_W-1:0] tok);
    predict_t p;
    p.hit  = 1'b1;
    p.rule = R_EMPTY;
    case (nt)
      NT_S: begin
        if (tok == TK_IF || tok == TK_WHILE) p.rule = R_S_B;
        else if (tok == TK_IDENT) p.rule = R_S_A;
        else p.hit = 1'b0;
      end
      NT_A: begin
        if (tok == TK_IDENT) p.rule = R_A;
        else p.hit = 1'b0;
      end
      NT_B: begin
        if (tok == TK_IF) p.rule = R_B_IF;
        else if (tok == TK_WHILE) p.rule = R_B_WHILE;
        else p.hit = 1'b0;
      end
      NT_E: begin
        if (tok == TK_IDENT || tok == TK_LPAR) p.rule = R_E;
        else p.hit = 1'b0;
      end
      NT_T: begin
        if (tok == TK_IDENT || tok == TK_LPAR) p.rule = R_T;
        else p.hit = 1'b0;
      end
      NT_G: begin
        if (tok == TK_PLUS) p.rule = R_G_PLUS;
        else if (tok == TK_MINUS) p.rule = R_G_MINUS;
        else if (tok == TK_RPAR || tok == TK_ASSIGN || tok == TK_IDENT ||
                 tok == TK_SEMI || tok == TK_MUL || tok == TK_DIV) p.rule = R_EMPTY;
        else p.hit = 1'b0;
      end
      NT_F: begin
        if (tok == TK_IDENT) p.rule = R_F_ID;
        else if (tok == TK_LPAR) p.rule = R_F_PAR;
        else p.hit = 1'b0;
      end
      NT_H: begin
        if (tok == TK_MUL) p.rule = R_H_MUL;
        else if (tok == TK_DIV) p.rule = R_H_DIV;
        else if (tok == TK_IDENT || tok == TK_PLUS || tok == TK_MINUS ||
                 tok == TK_RPAR || tok == TK_SEMI) p.rule = R_EMPTY;
        else p.hit = 1'b0;
      end
      NT_I: begin
        if (tok == TK_ELSE) p.rule = R_I_ELSE;
        else p.hit = 1'b0;
      end
      default: p.hit = 1'b0;
    endcase
    return p;
  endfunction

  function automatic logic [LEN_W-1:0] rule_len(input logic [RULE_W-1:0] r);
    logic [LEN_W-1:0] n;
    case (r)
      R_S_B, R_S_A, R_F_ID:                        n = 3'd1;
      R_B_IF:                                      n = 3'd5;
      R_B_WHILE, R_A:                              n = 3'd4;
      R_E, R_T, R_I_ELSE:                          n = 3'd2;
      R_G_PLUS, R_G_MINUS, R_F_PAR, R_H_MUL, R_H_DIV: n = 3'd3;
      default:                                     n = 3'd0;
    endcase
    return n;
  endfunction

  // entry k is the k-th symbol of the right side; entry 0 ends on top
  function automatic rule_syms_t rule_syms(input logic [RULE_W-1:0] r);
    rule_syms_t s;
    s = '0;
    case (r)
      R_S_B:     s[0] = NT_B;
      R_S_A:     s[0] = NT_A;
      R_B_IF:    begin
        s[0] = SY_IF; s[1] = SY_IDENT; s[2] = SY_THEN; s[3] = NT_A; s[4] = NT_I;
      end
      R_B_WHILE: begin
        s[0] = SY_WHILE; s[1] = SY_IDENT; s[2] = SY_DO; s[3] = NT_A;
      end
      R_A:       begin
        s[0] = SY_IDENT; s[1] = SY_ASSIGN; s[2] = NT_E; s[3] = SY_SEMI;
      end
      R_E:       begin s[0] = NT_T; s[1] = NT_G; end
      R_T:       begin s[0] = NT_F; s[1] = NT_H; end
      R_G_PLUS:  begin s[0] = SY_PLUS; s[1] = NT_T; s[2] = NT_G; end
      R_G_MINUS: begin s[0] = SY_MINUS; s[1] = NT_T; s[2] = NT_G; end
      R_F_ID:    s[0] = SY_IDENT;
      R_F_PAR:   begin s[0] = SY_LPAR; s[1] = NT_E; s[2] = SY_RPAR; end
      R_H_MUL:   begin s[0] = SY_MUL; s[1] = NT_F; s[2] = NT_H; end
      R_H_DIV:   begin s[0] = SY_DIV; s[1] = NT_F; s[2] = NT_H; end
      R_I_ELSE:  begin s[0] = SY_ELSE; s[1] = NT_A; end
      default:   s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [KIND_W-1:0] kind_of(input logic [FLAG_W-1:0] f);
    logic [KIND_W-1:0] k;
    case (f)
      4'd1:    k = 3'd1;
      4'd2:    k = 3'd2;
      4'd4:    k = 3'd3;
      4'd8:    k = 3'd4;
      4'd9:    k = 3'd5;
      4'd10:   k = 3'd6;
      4'd12:   k = 3'd7;
      default: k = 3'd0;
    endcase
    return k;
  endfunction

endpackage

### rtl/ll1p_token_if.sv
// ll1p_token_if: token channel of the ll1 statement parser
// depends on ll1p_pkg for the token width
interface ll1p_token_if;
  logic                          valid;
  logic                          ready;
  logic [ll1p_pkg::TOK_W-1:0]    token_id;

  modport source (output valid, output token_id, input ready);
  modport sink   (input valid, input token_id, output ready);
endinterface

### rtl/ll1p_result_if.sv
// ll1p_result_if: result channel of the ll1 statement parser
// depends on ll1p_pkg for the kind width
interface ll1p_result_if;
  logic                          valid;
  logic                          ready;
  logic                          token_taken;
  logic                          sentence_done;
  logic [ll1p_pkg::KIND_W-1:0]   sentence_kind;
  logic                          syntax_error;
  logic                          input_ended;

  modport source (output valid, output token_taken, output sentence_done,
                  output sentence_kind, output syntax_error, output input_ended,
                  input ready);
  modport sink   (input valid, input token_taken, input sentence_done,
                  input sentence_kind, input syntax_error, input input_ended,
                  output ready);
endinterface

### rtl/ll1p_cell.sv
// ll1p_cell: one entry of the symbol stack chain
// depends on ll1p_pkg for the stack command and symbol widths
module ll1p_cell (
  input  logic                                   clk,
  input  logic                                   rst,
  input  ll1p_pkg::stack_cmd_t                   cmd,
  input  logic [ll1p_pkg::LEN_W-1:0]             slot,
  input  logic [ll1p_pkg::SYM_W-1:0]             rule_sym,
  input  logic [ll1p_pkg::SYM_W-1:0]             above,
  input  logic [ll1p_pkg::RULE_MAX-1:0][ll1p_pkg::SYM_W-1:0] below,
  output logic [ll1p_pkg::SYM_W-1:0]             sym
);

  logic [ll1p_pkg::SYM_W-1:0] sym_next;
  logic [ll1p_pkg::SYM_W-1:0] start_sym;

  assign start_sym = (slot == '0) ? ll1p_pkg::NT_S : '0;

  always_comb begin
    sym_next = sym;
    case (cmd.op)
      ll1p_pkg::OP_RESTART: sym_next = start_sym;
      ll1p_pkg::OP_EXPAND: begin
        if (slot < cmd.len) begin
          sym_next = rule_sym;
        end else if (cmd.len == '0) begin
          // plain pop: move up one place
          sym_next = above;
        end else begin
          sym_next = below[cmd.len - ll1p_pkg::LEN_W'(1)];
        end
      end
      default: sym_next = sym;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sym <= start_sym;
    end else begin
      sym <= sym_next;
    end
  end

endmodule

### rtl/ll1p_stack.sv
// ll1p_stack: symbol stack as a row of cells with the top in cell zero, plus fill count
// depends on ll1p_pkg and ll1p_cell
module ll1p_stack (
  input  logic                             clk,
  input  logic                             rst,
  input  ll1p_pkg::stack_cmd_t             cmd,
  output logic [ll1p_pkg::SYM_W-1:0]       top,
  output logic [ll1p_pkg::FILL_W-1:0]      fill
);

  localparam int DEPTH = ll1p_pkg::STACK_DEPTH;

  logic [ll1p_pkg::SYM_W-1:0] cell_sym [DEPTH];
  logic [ll1p_pkg::FILL_W-1:0] fill_next;

  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    logic [ll1p_pkg::SYM_W-1:0]                          above;
    logic [ll1p_pkg::SYM_W-1:0]                          rule_sym;
    logic [ll1p_pkg::RULE_MAX-1:0][ll1p_pkg::SYM_W-1:0]  below;
    logic [ll1p_pkg::LEN_W-1:0]                          slot;

    if (j + 1 < DEPTH) begin : g_above
      assign above = cell_sym[j+1];
    end else begin : g_bottom
      assign above = '0;
    end

    if (j < ll1p_pkg::RULE_MAX) begin : g_rule
      assign rule_sym = cmd.syms[j];
      assign slot     = ll1p_pkg::LEN_W'(j);
    end else begin : g_norule
      assign rule_sym = '0;
      assign slot     = ll1p_pkg::LEN_W'(ll1p_pkg::RULE_MAX);
    end

    // below[k] is the cell k places nearer the top
    for (genvar k = 0; k < ll1p_pkg::RULE_MAX; k++) begin : g_below
      if (j - k >= 0) begin : g_in
        assign below[k] = cell_sym[j-k];
      end else begin : g_out
        assign below[k] = '0;
      end
    end

    ll1p_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .slot     (slot),
      .rule_sym (rule_sym),
      .above    (above),
      .below    (below),
      .sym      (cell_sym[j])
    );
  end

  assign top = cell_sym[0];

  always_comb begin
    fill_next = fill;
    case (cmd.op)
      ll1p_pkg::OP_RESTART: fill_next = ll1p_pkg::FILL_W'(1);
      ll1p_pkg::OP_EXPAND:
        fill_next = fill - ll1p_pkg::FILL_W'(1) + ll1p_pkg::FILL_W'(cmd.len);
      default: fill_next = fill;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= ll1p_pkg::FILL_W'(1);
    end else begin
      fill <= fill_next;
    end
  end

endmodule

### rtl/ll1_statement_parser.sv
// ll1_statement_parser: top level, parse sequencer and result register
// depends on ll1p_pkg, ll1p_token_if, ll1p_result_if and ll1p_stack
//
// Table-driven LL(1) parser for assignments, if-then, if-then-else and
// while-do statements. Each accepted token word gives exactly one result
// word: whether the token was consumed, whether a statement ended (with its
// kind), a syntax error, or the end-of-input mark (token 0, which drops any
// open statement, clears a latched error and restarts the parser). After
// an error every nonzero token answers with syntax_error until a token 0.
// A constant token is parsed as an identifier. The symbol stack is a chain
// of cells with the top in cell zero; one expansion or one terminal match
// is done per clock. A token is registered on entry, then stack steps run
// until the top matches it or an error ends it: nonterminals on top expand
// first, and a missing else closes an if-then before the token is parsed
// anew. End of input and a latched error finish in the first step. The last
// step of a token waits while the output register is still full. The next
// token is taken while the previous result still waits in the output register.
module ll1_statement_parser (
  input  logic               clk,
  input  logic               rst,
  ll1p_token_if.sink         tokens,
  ll1p_result_if.source      results
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t                              state;
  logic [ll1p_pkg::TOK_W-1:0]          tok;
  logic                                err_latched;
  logic [ll1p_pkg::FLAG_W-1:0]         flags;
  logic [ll1p_pkg::ITER_W-1:0]         iter;
  logic                                done_acc;
  logic [ll1p_pkg::KIND_W-1:0]         kind_acc;

  // stack chain view
  ll1p_pkg::stack_cmd_t                cmd;
  ll1p_pkg::stack_cmd_t                cmd_eff;
  logic [ll1p_pkg::SYM_W-1:0]          top;
  logic [ll1p_pkg::FILL_W-1:0]         fill;

  // one parse step
  ll1p_pkg::predict_t                  pred;
  logic [ll1p_pkg::FILL_W:0]           grow;
  logic                                finish;
  logic                                set_err;
  logic                                r_taken;
  logic                                r_done;
  logic [ll1p_pkg::KIND_W-1:0]         r_kind;
  logic                                r_ended;
  logic [ll1p_pkg::FLAG_W-1:0]         flags_next;
  logic                                done_next;
  logic [ll1p_pkg::KIND_W-1:0]         kind_next;
  logic                                slot_free;
  logic                                act;

  assign tokens.ready = (state == ST_IDLE);
  assign slot_free    = !results.valid || results.ready;
  // a step that ends the token needs the output register
  assign act          = (state == ST_RUN) && (!finish || slot_free);
  assign cmd_eff      = act ? cmd
                            : ll1p_pkg::stack_cmd_t'{op: ll1p_pkg::OP_NOP, len: '0, syms: '0};

  assign pred = ll1p_pkg::predict(top, tok);
  assign grow = {1'b0, fill - ll1p_pkg::FILL_W'(1)}
              + (ll1p_pkg::FILL_W + 1)'(ll1p_pkg::rule_len(pred.rule));

  always_comb begin
    cmd        = '{op: ll1p_pkg::OP_NOP, len: '0, syms: '0};
    finish     = 1'b0;
    set_err    = 1'b0;
    r_taken    = 1'b0;
    r_done     = done_acc;
    r_kind     = kind_acc;
    r_ended    = 1'b0;
    flags_next = flags;
    done_next  = done_acc;
    kind_next  = kind_acc;

    if (tok == ll1p_pkg::TK_END) begin
      // end of input: restart with the start symbol
      cmd.op     = ll1p_pkg::OP_RESTART;
      finish     = 1'b1;
      r_ended    = 1'b1;
      r_done     = 1'b0;
      flags_next = '0;
    end else if (err_latched) begin
      finish  = 1'b1;
      set_err = 1'b1;
    end else if (iter >= ll1p_pkg::ITER_W'(ll1p_pkg::MAX_EXPAND) || fill == '0) begin
      finish  = 1'b1;
      set_err = 1'b1;
    end else if (top >= ll1p_pkg::NT_S) begin
      if (!pred.hit) begin
        if (top == ll1p_pkg::NT_I && fill == ll1p_pkg::FILL_W'(1)) begin
          // no else follows: close the if-then and parse the token anew
          done_next  = 1'b1;
          kind_next  = ll1p_pkg::kind_of(flags);
          flags_next = '0;
          cmd.op     = ll1p_pkg::OP_EXPAND;
          cmd.len    = ll1p_pkg::LEN_W'(1);
          cmd.syms[0] = ll1p_pkg::NT_S;
        end else begin
          finish  = 1'b1;
          set_err = 1'b1;
        end
      end else begin
        case (pred.rule)
          ll1p_pkg::R_A:       flags_next = flags + ll1p_pkg::FLAG_W'(8);
          ll1p_pkg::R_B_IF:    flags_next = ll1p_pkg::FLAG_W'(1);
          ll1p_pkg::R_B_WHILE: flags_next = ll1p_pkg::FLAG_W'(4);
          ll1p_pkg::R_I_ELSE:  flags_next = ll1p_pkg::FLAG_W'(2);
          default:             flags_next = flags;
        endcase
        if (grow > (ll1p_pkg::FILL_W + 1)'(ll1p_pkg::STACK_DEPTH)) begin
          finish  = 1'b1;
          set_err = 1'b1;
        end else begin
          cmd.op   = ll1p_pkg::OP_EXPAND;
          cmd.len  = ll1p_pkg::rule_len(pred.rule);
          cmd.syms = ll1p_pkg::rule_syms(pred.rule);
        end
      end
    end else if (top != {1'b0, tok}) begin
      finish  = 1'b1;
      set_err = 1'b1;
    end else begin
      // terminal match consumes the token
      finish  = 1'b1;
      r_taken = 1'b1;
      cmd.op  = ll1p_pkg::OP_EXPAND;
      cmd.len = '0;
      if (fill == ll1p_pkg::FILL_W'(1)) begin
        // stack emptied: statement complete, start over
        r_done      = 1'b1;
        r_kind      = ll1p_pkg::kind_of(flags);
        flags_next  = '0;
        cmd.len     = ll1p_pkg::LEN_W'(1);
        cmd.syms[0] = ll1p_pkg::NT_S;
      end
    end
  end

  ll1p_stack u_stack (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd_eff),
    .top  (top),
    .fill (fill)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      err_latched   <= 1'b0;
      flags         <= '0;
      iter          <= '0;
      done_acc      <= 1'b0;
      kind_acc      <= '0;
      results.valid <= 1'b0;
    end else begin
      // a new result word in the same cycle keeps valid high
      if (results.valid && results.ready && !(act && finish)) begin
        results.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (tokens.valid) begin
            tok      <= (tokens.token_id == ll1p_pkg::TK_CONST) ? ll1p_pkg::TK_IDENT
                                                                : tokens.token_id;
            iter     <= '0;
            done_acc <= 1'b0;
            kind_acc <= '0;
            state    <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (act) begin
            flags    <= flags_next;
            done_acc <= done_next;
            kind_acc <= kind_next;
            iter     <= iter + ll1p_pkg::ITER_W'(1);
            if (r_ended) begin
              err_latched <= 1'b0;
            end else if (set_err) begin
              err_latched <= 1'b1;
            end
            if (finish) begin
              results.valid         <= 1'b1;
              results.token_taken   <= r_taken;
              results.sentence_done <= r_done;
              results.sentence_kind <= r_done ? r_kind : '0;
              results.syntax_error  <= set_err;
              results.input_ended   <= r_ended;
              state                 <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### tb/ll1p_parse_checker.sv
// ll1p_parse_checker: watches the token and result channels of the ll1 statement
// parser, predicts every result word and compares it field by field
// depends on ll1p_pkg, ll1p_token_if and ll1p_result_if
module ll1p_parse_checker
  import ll1p_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  ll1p_token_if  tokens,
  ll1p_result_if results,
  output int     mismatches,
  output int     pending_words
);

  // sentence flag bits set by the chosen rules
  localparam logic [FLAG_W-1:0] FL_IF     = 4'd1;
  localparam logic [FLAG_W-1:0] FL_ELSE   = 4'd2;
  localparam logic [FLAG_W-1:0] FL_WHILE  = 4'd4;
  localparam logic [FLAG_W-1:0] FL_ASSIGN = 4'd8;

  // sentence kinds as reported
  localparam logic [KIND_W-1:0] K_OTHER        = 3'd0;
  localparam logic [KIND_W-1:0] K_IF           = 3'd1;
  localparam logic [KIND_W-1:0] K_IF_ELSE      = 3'd2;
  localparam logic [KIND_W-1:0] K_WHILE        = 3'd3;
  localparam logic [KIND_W-1:0] K_ASSIGN       = 3'd4;
  localparam logic [KIND_W-1:0] K_IF_ASSIGN    = 3'd5;
  localparam logic [KIND_W-1:0] K_ELSE_ASSIGN  = 3'd6;
  localparam logic [KIND_W-1:0] K_WHILE_ASSIGN = 3'd7;

  localparam int NO_RULE    = -1;

  typedef logic [RULE_MAX-1:0][SYM_W-1:0] rhs_t;

  typedef struct packed {
    logic              taken;
    logic              done;
    logic [KIND_W-1:0] kind;
    logic              err;
    logic              ended;
  } parse_word_t;

  logic [SYM_W-1:0]  sym_stack [STACK_DEPTH];
  int                stack_depth;
  logic [FLAG_W-1:0] sent_flags;
  bit                err_held;
  parse_word_t       expected_q [$];
  parse_word_t       want;
  int                word_no;

  function automatic void parser_restart();
    for (int k = 0; k < STACK_DEPTH; k++) sym_stack[k] = '0;
    sym_stack[0] = NT_S;
    stack_depth  = 1;
    sent_flags   = '0;
    err_held     = 1'b0;
  endfunction

  function automatic logic [KIND_W-1:0] kind_from_flags(input logic [FLAG_W-1:0] f);
    case (f)
      FL_IF:              return K_IF;
      FL_ELSE:            return K_IF_ELSE;
      FL_WHILE:           return K_WHILE;
      FL_ASSIGN:          return K_ASSIGN;
      FL_ASSIGN | FL_IF:  return K_IF_ASSIGN;
      FL_ASSIGN | FL_ELSE:  return K_ELSE_ASSIGN;
      FL_ASSIGN | FL_WHILE: return K_WHILE_ASSIGN;
      default:            return K_OTHER;
    endcase
  endfunction

  // parse table: rule for nonterminal nt under lookahead t
  function automatic int pick_rule(input logic [SYM_W-1:0] nt, input logic [TOK_W-1:0] t);
    case (nt)
      NT_S: begin
        if (t == TK_IF || t == TK_WHILE) return int'(R_S_B);
        if (t == TK_IDENT) return int'(R_S_A);
      end
      NT_A: if (t == TK_IDENT) return int'(R_A);
      NT_B: begin
        if (t == TK_IF) return int'(R_B_IF);
        if (t == TK_WHILE) return int'(R_B_WHILE);
      end
      NT_E, NT_T: if (t == TK_IDENT || t == TK_LPAR) return (nt == NT_E) ? int'(R_E) : int'(R_T);
      NT_G: begin
        if (t == TK_PLUS) return int'(R_G_PLUS);
        if (t == TK_MINUS) return int'(R_G_MINUS);
        if (t == TK_RPAR || t == TK_ASSIGN || t == TK_IDENT || t == TK_SEMI ||
            t == TK_MUL || t == TK_DIV) return int'(R_EMPTY);
      end
      NT_F: begin
        if (t == TK_IDENT) return int'(R_F_ID);
        if (t == TK_LPAR) return int'(R_F_PAR);
      end
      NT_H: begin
        if (t == TK_MUL) return int'(R_H_MUL);
        if (t == TK_DIV) return int'(R_H_DIV);
        if (t == TK_IDENT || t == TK_PLUS || t == TK_MINUS || t == TK_RPAR ||
            t == TK_SEMI) return int'(R_EMPTY);
      end
      NT_I: if (t == TK_ELSE) return int'(R_I_ELSE);
      default: return NO_RULE;
    endcase
    return NO_RULE;
  endfunction

  // right-hand side of rule r, leftmost symbol in entry 0
  function automatic int rule_rhs(input int r, output rhs_t b);
    b = '0;
    case (r)
      R_S_B:     begin b[0] = NT_B; return 1; end
      R_S_A:     begin b[0] = NT_A; return 1; end
      R_B_IF:    begin
        b[0] = SY_IF; b[1] = SY_IDENT; b[2] = SY_THEN; b[3] = NT_A; b[4] = NT_I;
        return 5;
      end
      R_B_WHILE: begin
        b[0] = SY_WHILE; b[1] = SY_IDENT; b[2] = SY_DO; b[3] = NT_A;
        return 4;
      end
      R_A:       begin
        b[0] = SY_IDENT; b[1] = SY_ASSIGN; b[2] = NT_E; b[3] = SY_SEMI;
        return 4;
      end
      R_E:       begin b[0] = NT_T; b[1] = NT_G; return 2; end
      R_T:       begin b[0] = NT_F; b[1] = NT_H; return 2; end
      R_G_PLUS:  begin b[0] = SY_PLUS; b[1] = NT_T; b[2] = NT_G; return 3; end
      R_G_MINUS: begin b[0] = SY_MINUS; b[1] = NT_T; b[2] = NT_G; return 3; end
      R_F_ID:    begin b[0] = SY_IDENT; return 1; end
      R_F_PAR:   begin b[0] = SY_LPAR; b[1] = NT_E; b[2] = SY_RPAR; return 3; end
      R_H_MUL:   begin b[0] = SY_MUL; b[1] = NT_F; b[2] = NT_H; return 3; end
      R_H_DIV:   begin b[0] = SY_DIV; b[1] = NT_F; b[2] = NT_H; return 3; end
      R_I_ELSE:  begin b[0] = SY_ELSE; b[1] = NT_A; return 2; end
      default:   return 0;
    endcase
  endfunction

  // one token through the predicted parser, updates its state
  function automatic parse_word_t parse_token(input logic [TOK_W-1:0] tin);
    parse_word_t      w;
    logic [TOK_W-1:0] t;
    logic [SYM_W-1:0] top;
    rhs_t             rhs;
    int               r;
    int               n;
    int               steps;
    bit               stop;
    w = '0;
    if (tin == TK_END) begin
      parser_restart();
      w.ended = 1'b1;
      return w;
    end
    if (err_held) begin
      w.err = 1'b1;
      return w;
    end
    t    = (tin == TK_CONST) ? TK_IDENT : tin;
    stop = 1'b0;
    for (steps = 0; !stop; steps++) begin
      if (steps >= MAX_EXPAND || stack_depth == 0 || stack_depth > STACK_DEPTH) begin
        w.err = 1'b1;
        stop  = 1'b1;
      end else begin
        stack_depth--;
        top = sym_stack[stack_depth];
        if (top >= NT_S) begin
          r = pick_rule(top, t);
          if (r == NO_RULE) begin
            if (top == NT_I && stack_depth == 0) begin
              // no else follows: the if-then closes, token parsed on
              w.done       = 1'b1;
              w.kind       = kind_from_flags(sent_flags);
              sent_flags   = '0;
              sym_stack[0] = NT_S;
              stack_depth  = 1;
            end else begin
              w.err = 1'b1;
              stop  = 1'b1;
            end
          end else begin
            if (r == R_A) sent_flags = sent_flags + FL_ASSIGN;
            if (r == R_B_IF) sent_flags = FL_IF;
            if (r == R_B_WHILE) sent_flags = FL_WHILE;
            if (r == R_I_ELSE) sent_flags = FL_ELSE;
            n = rule_rhs(r, rhs);
            if (stack_depth + n > STACK_DEPTH) begin
              w.err = 1'b1;
              stop  = 1'b1;
            end else begin
              for (int k = n - 1; k >= 0; k--) begin
                sym_stack[stack_depth] = rhs[k];
                stack_depth++;
              end
            end
          end
        end else begin
          if (top != {1'b0, t}) begin
            w.err = 1'b1;
          end else begin
            w.taken = 1'b1;
            if (stack_depth == 0) begin
              w.done       = 1'b1;
              w.kind       = kind_from_flags(sent_flags);
              sent_flags   = '0;
              sym_stack[0] = NT_S;
              stack_depth  = 1;
            end
          end
          stop = 1'b1;
        end
      end
    end
    if (w.err) err_held = 1'b1;
    if (!w.done) w.kind = K_OTHER;
    return w;
  endfunction

  task automatic report_mismatch(input string field, input logic [3:0] got,
                                 input logic [3:0] exp_val);
    mismatches++;
    $display("result word %0d: %s is %0d, predicted %0d", word_no, field, got, exp_val);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      parser_restart();
      expected_q.delete();
      mismatches = 0;
      word_no    = 0;
    end else begin
      if (results.valid && results.ready) begin
        word_no++;
        if (expected_q.size() == 0) begin
          report_mismatch("word with none pending", 4'd1, 4'd0);
        end else begin
          want = expected_q.pop_front();
          if (results.token_taken !== want.taken)
            report_mismatch("token_taken", 4'(results.token_taken), 4'(want.taken));
          if (results.sentence_done !== want.done)
            report_mismatch("sentence_done", 4'(results.sentence_done), 4'(want.done));
          if (results.sentence_kind !== want.kind)
            report_mismatch("sentence_kind", 4'(results.sentence_kind), 4'(want.kind));
          if (results.syntax_error !== want.err)
            report_mismatch("syntax_error", 4'(results.syntax_error), 4'(want.err));
          if (results.input_ended !== want.ended)
            report_mismatch("input_ended", 4'(results.input_ended), 4'(want.ended));
        end
      end
      if (tokens.valid && tokens.ready)
        expected_q.push_back(parse_token(tokens.token_id));
    end
    pending_words <= expected_q.size();
  end

endmodule

### tb/tb_ll1_statement_parser.sv
// tb_ll1_statement_parser: stimulus and verdict for the ll1 statement parser
// depends on ll1p_pkg, both channel interfaces, the parser and ll1p_parse_checker
module tb_ll1_statement_parser;
  import ll1p_pkg::*;

  localparam int ITEMS       = 900;
  localparam int MAX_GAP     = 17;
  localparam int HOLD_CYCLES = 150;
  localparam int HOLD_AT_A   = 250;
  localparam int HOLD_AT_B   = 620;
  localparam int DRAIN       = 24;
  localparam int TIME_LIMIT  = 2_000_000;

  // tokens the grammar never uses: every one of them is a syntax error
  localparam logic [TOK_W-1:0] TK_P     = 5'd1;
  localparam logic [TOK_W-1:0] TK_B     = 5'd2;
  localparam logic [TOK_W-1:0] TK_PLUS2 = 5'd19;
  localparam logic [TOK_W-1:0] TK_TOP   = 5'd31;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  bit   hold_req = 1'b0;   // asks the result side for one long stall
  bit   quiet_now = 1'b0;  // no idling on either side while set

  ll1p_token_if  tok_ch ();
  ll1p_result_if res_ch ();

  ll1_statement_parser dut (
    .clk     (clk),
    .rst     (rst),
    .tokens  (tok_ch),
    .results (res_ch)
  );

  ll1p_parse_checker chk (
    .clk           (clk),
    .rst           (rst),
    .tokens        (tok_ch),
    .results       (res_ch),
    .mismatches    (fail_count),
    .pending_words (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // single reset at the start
  initial begin
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  // hard stop in case the handshake hangs
  initial begin
    #(TIME_LIMIT);
    $display("ll1_statement_parser: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // token stream builder
  // ---------------------------------------------------------------------------
  logic [TOK_W-1:0] stream [$];

  task automatic put(input logic [TOK_W-1:0] t);
    stream.push_back(t);
  endtask

  // constants are parsed as identifiers, so mix both in
  function automatic logic [TOK_W-1:0] any_ident();
    return ($urandom_range(0, 3) == 0) ? TK_CONST : TK_IDENT;
  endfunction

  // id := expr ; with a random expression, parens nested up to two deep
  task automatic add_assignment();
    int open_n;
    int ops;
    open_n = 0;
    ops    = 0;
    put(any_ident());
    put(TK_ASSIGN);
    forever begin
      while (open_n < 2 && $urandom_range(0, 3) == 0) begin
        put(TK_LPAR);
        open_n++;
      end
      put(any_ident());
      while (open_n > 0 && $urandom_range(0, 2) == 0) begin
        put(TK_RPAR);
        open_n--;
      end
      if (ops >= 4 || $urandom_range(0, 2) == 0) begin
        while (open_n > 0) begin
          put(TK_RPAR);
          open_n--;
        end
        break;
      end
      case ($urandom_range(0, 3))
        0:       put(TK_PLUS);
        1:       put(TK_MINUS);
        2:       put(TK_MUL);
        default: put(TK_DIV);
      endcase
      ops++;
    end
    put(TK_SEMI);
  endtask

  // one well-formed statement; an if without else closes on the next token
  task automatic add_statement();
    case ($urandom_range(0, 3))
      0: begin
        put(TK_IF); put(any_ident()); put(TK_THEN);
        add_assignment();
        if ($urandom_range(0, 1)) begin
          put(TK_ELSE);
          add_assignment();
        end
      end
      1: begin
        put(TK_WHILE); put(any_ident()); put(TK_DO);
        add_assignment();
      end
      default: add_assignment();
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // token side: builds the stream, then offers one word per token
  // ---------------------------------------------------------------------------
  initial begin : token_side
    int idx;
    int gap;
    int first;
    int cut;
    int nest;
    int roll;
    tok_ch.valid    <= 1'b0;
    tok_ch.token_id <= TK_END;

    // directed: assignment of constants, an if-then whose else never comes
    // (closed by the following while), unknown tokens with the error latch,
    // end of input in the middle of a statement
    put(TK_CONST); put(TK_ASSIGN); put(TK_CONST); put(TK_SEMI);
    put(TK_IF); put(TK_IDENT); put(TK_THEN);
    put(TK_IDENT); put(TK_ASSIGN); put(TK_IDENT); put(TK_SEMI);
    put(TK_WHILE); put(TK_IDENT); put(TK_DO);
    put(TK_IDENT); put(TK_ASSIGN); put(TK_IDENT); put(TK_SEMI);
    put(TK_TOP); put(TK_P); put(TK_END);
    put(TK_IDENT); put(TK_ASSIGN); put(TK_END);
    put(TK_B); put(TK_END);
    put(TK_PLUS2); put(TK_END);

    // random part, mostly well-formed statements
    while (stream.size() < 28 + ITEMS) begin
      roll  = $urandom_range(0, 99);
      first = stream.size();
      if (roll < 76) begin
        add_statement();
        // now and then one token broken, then a restart
        if ($urandom_range(0, 9) == 0) begin
          stream[$urandom_range(first, stream.size() - 1)] = TOK_W'($urandom_range(1, 31));
          put(TK_END);
        end
      end else if (roll < 82) begin
        // deep parens: about ten levels overflow the symbol stack
        nest = $urandom_range(7, 13);
        put(any_ident());
        put(TK_ASSIGN);
        repeat (nest) put(TK_LPAR);
        put(any_ident());
        repeat (nest) put(TK_RPAR);
        put(TK_SEMI);
        put(TK_END);
      end else if (roll < 90) begin
        // statement cut short by end of input
        add_statement();
        cut = $urandom_range(first + 1, stream.size() - 1);
        while (stream.size() > cut) void'(stream.pop_back());
        put(TK_END);
      end else begin
        put(TOK_W'($urandom_range(1, 31)));
        if ($urandom_range(0, 1)) put(TK_END);
      end
    end

    @(posedge clk);
    while (rst) @(posedge clk);

    for (idx = 0; idx < stream.size(); idx++) begin
      // stretches with no idling around each long result stall, so the
      // parser fills up and pushes back on the token side
      quiet_now = (idx >= HOLD_AT_A - 20 && idx < HOLD_AT_A + 60) ||
                  (idx >= HOLD_AT_B - 20 && idx < HOLD_AT_B + 60);
      if (idx == HOLD_AT_A || idx == HOLD_AT_B) hold_req = 1'b1;
      gap = quiet_now ? 0 : $urandom_range(0, MAX_GAP);
      // valid drops only when a gap follows, so it is never lowered and
      // raised in the same step
      if (gap > 0) begin
        tok_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      tok_ch.valid    <= 1'b1;
      tok_ch.token_id <= stream[idx];
      @(posedge clk);
      while (!tok_ch.ready) @(posedge clk);
    end
    tok_ch.valid <= 1'b0;
    quiet_now = 1'b0;

    // pending count is registered, so let it catch up before trusting it
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (fail_count == 0)
      $display("ll1_statement_parser: match");
    else
      $display("ll1_statement_parser: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side: random stall before each word, one long hold on request
  // ---------------------------------------------------------------------------
  initial begin : result_side
    int gap;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        gap = quiet_now ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
          res_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
    end
  end

endmodule
